// ----- hw/rtl/rc_receiver_frame_decoder_core_macros.svh -----
// Assertion macros for the frame decoder checker.
`ifndef RC_RECEIVER_FRAME_DECODER_CORE_MACROS_SVH
`define RC_RECEIVER_FRAME_DECODER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RCD_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RCD_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/rcd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcd_pkg
// Types and constants shared by the frame decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none
package rcd_pkg;
  localparam int FRAME_BYTES = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL = 3'd4;

  // Request to the shared scaler: numerator and divisor.
  typedef struct packed {
    logic        start;
    logic [21:0] num;
    logic [10:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [10:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- hw/rtl/rcd_if.sv -----
// ----------------------------------------------------------------------------
// rcd_in_if / rcd_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface rcd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface rcd_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] right_stick_x;
  logic signed [10:0] right_stick_y;
  logic signed [10:0] left_stick_x;
  logic signed [10:0] left_stick_y;
  logic signed [10:0] wheel;
  logic [1:0]         right_switch;
  logic [1:0]         left_switch;
  logic signed [15:0] mouse_x;
  logic signed [15:0] mouse_y;
  logic signed [15:0] mouse_z;
  logic [17:0]        buttons_and_keys;
  logic [4:0]         status;
  modport source (output valid, output right_stick_x, output right_stick_y,
                  output left_stick_x, output left_stick_y, output wheel,
                  output right_switch, output left_switch, output mouse_x,
                  output mouse_y, output mouse_z, output buttons_and_keys,
                  output status, input ready);
  modport sink (input valid, input right_stick_x, input right_stick_y,
                input left_stick_x, input left_stick_y, input wheel,
                input right_switch, input left_switch, input mouse_x,
                input mouse_y, input mouse_z, input buttons_and_keys,
                input status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rcd_ram.sv -----
// ----------------------------------------------------------------------------
// rcd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module rcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 18
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    rdata <= mem_r[addr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rcd_divider.sv -----
// ----------------------------------------------------------------------------
// rcd_divider
// Restoring divider, one quotient bit per cycle, 11-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module rcd_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rcd_pkg::div_req_t req,
  output rcd_pkg::div_rsp_t      rsp
);
  logic [21:0] rem_r;
  logic [10:0] den_r;
  logic [10:0] quot_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [11:0] trial;
  logic [11:0] diff;

  // The quotient never exceeds 2000, so the top 11 numerator bits stay below
  // the divisor and eleven steps suffice.
  assign trial = {rem_r[21:11], rem_r[10]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        rem_r  <= req.num;
        den_r  <= req.den;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        if (!diff[11]) begin
          rem_r  <= {diff[10:0], rem_r[9:0], 1'b0};
          quot_r <= {quot_r[9:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[20:0], 1'b0};
          quot_r <= {quot_r[9:0], 1'b0};
        end
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd10) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
  assign rsp = {done_r, quot_r};
endmodule
`default_nettype wire

// ----- hw/rtl/rc_receiver_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder_core
// Frames receiver bytes, unpacks and scales channels, tracks link health.
// ----------------------------------------------------------------------------
// A tick or an ordinary byte goes through the step state to its result.
// The last byte of a frame triggers the decode: eighteen bytes are read back
// from the frame RAM one per cycle, the last byte is captured, the fields are
// unpacked and the channel range is checked, then each of the five channels
// is scaled in turn by the shared eleven-step divider; the divider is skipped
// when the frame is invalid or low equals high. The block takes no new item
// until its result has been delivered, and is ready again in the cycle after
// that.
`default_nettype none
module rc_receiver_frame_decoder_core #(
  parameter int FRAME_BYTES = rcd_pkg::FRAME_BYTES
) (
  input wire logic clk,
  input wire logic rst_n,
  rcd_in_if.sink   in_ch,
  rcd_out_if.source out_ch,
  input wire logic                         cfg_we,
  input wire logic [rcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int AW = $clog2(FRAME_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_READ, S_CHECK, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic [10:0] low_r, high_r;
  logic [15:0] gap_r, sil_r;
  logic [23:0] disc_r, fail_r, since_f_r, since_v_r;
  logic [4:0]  idx_r;
  logic        link_r, failed_r, valid_r, chg_r, done_r;
  logic [10:0] scaled_r [5];
  logic [10:0] ch_r [5];
  logic [1:0]  rsw_r, lsw_r, prev_r;
  logic [15:0] mx_r, my_r, mz_r, keys_r;
  logic [1:0]  btn_r;
  logic [7:0]  fb_r [FRAME_BYTES];
  logic [4:0]  rd_r;
  logic        rd_v_r;
  logic [2:0]  ch_i_r;
  logic        mode_r;
  logic [7:0]  byte_r;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [7:0]        ram_q;
  rcd_pkg::div_req_t dreq;
  rcd_pkg::div_rsp_t drsp;
  logic [4:0]        idx_start;
  logic              ok;
  logic [10:0]       span;

  rcd_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(byte_r), .rdata(ram_q)
  );
  rcd_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign idx_start = (sil_r >= gap_r || idx_r >= 5'(FRAME_BYTES)) ? 5'd0 : idx_r;
  assign ram_we    = (state_r == S_STEP) && !mode_r;
  assign ram_addr  = (state_r == S_STEP) ? idx_start[AW-1:0] : rd_r[AW-1:0];
  assign span      = high_r - low_r;

  always_comb begin
    ok = 1'b1;
    for (int i = 0; i < 5; i++)
      if (ch_r[i] < low_r || ch_r[i] > high_r) ok = 1'b0;
  end

  always_comb begin
    dreq.start = (state_r == S_CHECK && ok && high_r > low_r) ||
                 (state_r == S_DIV && drsp.done && ch_i_r != 3'd4);
    dreq.num = 22'((ch_r[(state_r == S_CHECK) ? 3'd0 : ch_i_r + 3'd1] - low_r))
               * 22'd2000;
    dreq.den = span;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.right_stick_x = scaled_r[0];
  assign out_ch.right_stick_y = scaled_r[1];
  assign out_ch.left_stick_x  = scaled_r[2];
  assign out_ch.left_stick_y  = scaled_r[3];
  assign out_ch.wheel         = scaled_r[4];
  assign out_ch.right_switch  = rsw_r;
  assign out_ch.left_switch   = lsw_r;
  assign out_ch.mouse_x = mx_r;
  assign out_ch.mouse_y = my_r;
  assign out_ch.mouse_z = mz_r;
  assign out_ch.buttons_and_keys = {btn_r, keys_r};
  assign out_ch.status = {chg_r, failed_r, link_r, valid_r, done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      low_r <= 11'd364; high_r <= 11'd1684; gap_r <= 16'd3000;
      disc_r <= 24'd250000; fail_r <= 24'd500000;
      idx_r <= '0; sil_r <= '0; since_f_r <= '0; since_v_r <= '0;
      link_r <= 1'b0; failed_r <= 1'b0; valid_r <= 1'b0; chg_r <= 1'b0;
      done_r <= 1'b0;
      for (int i = 0; i < 5; i++) scaled_r[i] <= '0;
      rsw_r <= '0; lsw_r <= '0; prev_r <= '0;
      mx_r <= '0; my_r <= '0; mz_r <= '0; keys_r <= '0; btn_r <= '0;
      rd_r <= '0; rd_v_r <= 1'b0; ch_i_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rcd_pkg::REG_LOW:  low_r  <= cfg_data[10:0];
          rcd_pkg::REG_HIGH: high_r <= cfg_data[10:0];
          rcd_pkg::REG_GAP:  gap_r  <= cfg_data[15:0];
          rcd_pkg::REG_DISC: disc_r <= cfg_data;
          rcd_pkg::REG_FAIL: fail_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_ch.valid) begin
          mode_r <= in_ch.mode;
          byte_r <= in_ch.data_byte;
          state_r <= S_STEP;
        end
        S_STEP: begin
          done_r <= 1'b0;
          if (mode_r) begin
            if (sil_r != 16'hFFFF) sil_r <= sil_r + 16'd1;
            if (since_f_r != 24'hFFFFFF) since_f_r <= since_f_r + 24'd1;
            if (since_v_r != 24'hFFFFFF) since_v_r <= since_v_r + 24'd1;
            // Compare uses the incremented count.
            if ((since_f_r != 24'hFFFFFF ? since_f_r + 24'd1 : since_f_r) > disc_r)
              link_r <= 1'b0;
            state_r <= S_OUT;
          end else begin
            sil_r <= '0;
            if (idx_start + 5'd1 >= 5'(FRAME_BYTES)) begin
              idx_r <= '0;
              rd_r <= '0; rd_v_r <= 1'b0;
              state_r <= S_READ;
            end else begin
              idx_r <= idx_start + 5'd1;
              state_r <= S_OUT;
            end
          end
        end
        S_READ: begin
          // The RAM word read last cycle lands now.
          rd_v_r <= 1'b1;
          if (rd_r != 5'(FRAME_BYTES - 1)) rd_r <= rd_r + 5'd1;
          if (rd_v_r || rd_r != 5'd0) begin
            fb_r[rd_v_r ? rd_r - 5'd1 : 5'd0] <= ram_q;
          end
          if (rd_v_r && rd_r == 5'(FRAME_BYTES - 1)) begin
            state_r <= S_FIN;
            ch_i_r <= 3'd7;
          end
        end
        S_FIN: begin
          if (ch_i_r == 3'd7) begin
            fb_r[FRAME_BYTES-1] <= ram_q;
            ch_i_r <= 3'd6;
          end else begin
            ch_r[0] <= {fb_r[1][2:0], fb_r[0]};
            ch_r[1] <= {fb_r[2][5:0], fb_r[1][7:3]};
            ch_r[2] <= {fb_r[4][0], fb_r[3], fb_r[2][7:6]};
            ch_r[3] <= {fb_r[5][3:0], fb_r[4][7:1]};
            ch_r[4] <= {fb_r[17][2:0], fb_r[16]};
            mx_r <= {fb_r[7], fb_r[6]};
            my_r <= {fb_r[9], fb_r[8]};
            mz_r <= {fb_r[11], fb_r[10]};
            btn_r <= {fb_r[13] != 8'd0, fb_r[12] != 8'd0};
            link_r <= 1'b1;
            since_f_r <= '0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          valid_r <= ok;
          done_r <= 1'b1;
          if (ok) begin
            failed_r <= 1'b0;
            since_v_r <= '0;
            rsw_r <= fb_r[5][5:4];
            lsw_r <= fb_r[5][7:6];
            keys_r <= {fb_r[15], fb_r[14]};
            chg_r <= fb_r[5][7:6] != prev_r;
            prev_r <= fb_r[5][7:6];
            ch_i_r <= 3'd0;
            if (high_r > low_r) state_r <= S_DIV;
            else begin
              for (int i = 0; i < 5; i++) scaled_r[i] <= 11'd1048;
              state_r <= S_OUT;
            end
          end else begin
            failed_r <= since_v_r > fail_r;
            state_r <= S_OUT;
          end
        end
        S_DIV: if (drsp.done) begin
          scaled_r[ch_i_r] <= drsp.quot + 11'd1048;
          ch_i_r <= ch_i_r + 3'd1;
          if (ch_i_r == 3'd4) state_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rcd_checker.sv -----
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks on the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rc_receiver_frame_decoder_core_macros.svh"
module rcd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] status
);
  // A new item is never taken while a result waits.
  `RCD_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  // A finished frame always reports the link as up.
  `RCD_ASSERT_IMP(a_done_link, clk, rst_n, out_valid && status[0], status[2])
  // A valid frame clears the failed flag.
  `RCD_ASSERT_IMP(a_valid_ok, clk, rst_n, out_valid && status[0] && status[1], !status[3])
  // A result stays until taken.
  `RCD_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind rc_receiver_frame_decoder_core rcd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.status)
);
`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Frame decoder testbench
// Drives bytes and ticks into the receiver frame decoder and checks every
// result against a cycle-free model of framing, decode, scaling and link
// health, across several register settings and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  localparam bit MODE_BYTE = 1'b0;
  localparam bit MODE_TICK = 1'b1;
  localparam logic [rcd_pkg::CFG_IDX_W-1:0] REG_BEYOND = 3'd5;
  localparam logic [rcd_pkg::CFG_IDX_W-1:0] REG_TOP = 3'd7;
  localparam int ST_DONE = 0;
  localparam int ST_VALID = 1;
  localparam int ST_LINK = 2;
  localparam int ST_FAILED = 3;
  localparam int ST_SWCHG = 4;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 1500;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [10:0] stick[5];
    logic [1:0]  rsw;
    logic [1:0]  lsw;
    logic [15:0] mouse[3];
    logic [17:0] btn_keys;
    logic [4:0]  status;
  } decoder_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  rcd_in_if in_if();
  rcd_out_if out_if();

  rc_receiver_frame_decoder_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Model state.
  logic [10:0] m_low = 11'd364, m_high = 11'd1684;
  logic [15:0] m_gap = 16'd3000;
  logic [23:0] m_disc = 24'd250000, m_fail = 24'd500000;
  logic [7:0]  m_store[rcd_pkg::FRAME_BYTES];
  int          m_idx = 0;
  logic [15:0] m_silence = '0;
  logic [23:0] m_since_frame = '0, m_since_valid = '0;
  bit          m_link = 0, m_failed = 0, m_swchg = 0, m_last_ok = 0;
  logic [10:0] m_scaled[5] = '{default: '0};
  logic [1:0]  m_sw[2] = '{default: '0};
  logic [1:0]  m_prev_left = '0;
  logic [15:0] m_mouse[3] = '{default: '0};
  logic [1:0]  m_buttons = '0;
  logic [15:0] m_keys = '0;

  decoder_out_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0, hold_ack = 0, hold_left = 0;
  int items_sent = 0;
  longint cycles = 0;

  function automatic logic [10:0] scale_value(logic [10:0] v);
    logic [31:0] q;
    q = 0;
    if (m_high > m_low) q = ((32'(v) - 32'(m_low)) * 32'd2000) / (32'(m_high) - 32'(m_low));
    return q[10:0] + 11'd1048;
  endfunction

  task automatic predict_step(bit m, logic [7:0] d);
    decoder_out_t r;
    bit done;
    bit ok;
    logic [10:0] ch[5];
    logic [1:0] left;
    done = 0;
    if (m == MODE_TICK) begin
      if (m_silence != 16'hFFFF) m_silence++;
      if (m_since_frame != 24'hFFFFFF) m_since_frame++;
      if (m_since_valid != 24'hFFFFFF) m_since_valid++;
      if (m_since_frame > m_disc) m_link = 0;
    end else begin
      if (m_silence >= m_gap) m_idx = 0;
      m_silence = 0;
      if (m_idx >= rcd_pkg::FRAME_BYTES) m_idx = 0;
      m_store[m_idx] = d;
      m_idx++;
      if (m_idx >= rcd_pkg::FRAME_BYTES) begin
        m_idx = 0;
        done = 1;
        ch[0] = {m_store[1][2:0], m_store[0]};
        ch[1] = {m_store[2][5:0], m_store[1][7:3]};
        ch[2] = {m_store[4][0], m_store[3], m_store[2][7:6]};
        ch[3] = {m_store[5][3:0], m_store[4][7:1]};
        ch[4] = {m_store[17][2:0], m_store[16]};
        m_mouse[0] = {m_store[7], m_store[6]};
        m_mouse[1] = {m_store[9], m_store[8]};
        m_mouse[2] = {m_store[11], m_store[10]};
        m_buttons = {m_store[13] != 0, m_store[12] != 0};
        m_link = 1;
        m_since_frame = 0;
        ok = 1;
        for (int i = 0; i < 5; i++)
          if (ch[i] < m_low || ch[i] > m_high) ok = 0;
        m_last_ok = ok;
        if (ok) begin
          m_failed = 0;
          m_since_valid = 0;
          for (int i = 0; i < 5; i++) m_scaled[i] = scale_value(ch[i]);
          m_sw[0] = m_store[5][5:4];
          left = m_store[5][7:6];
          m_sw[1] = left;
          m_keys = {m_store[15], m_store[14]};
          m_swchg = (left != m_prev_left);
          m_prev_left = left;
        end else begin
          m_failed = (m_since_valid > m_fail);
        end
      end
    end
    r.stick = m_scaled;
    r.rsw = m_sw[0];
    r.lsw = m_sw[1];
    r.mouse = m_mouse;
    r.btn_keys = {m_buttons, m_keys};
    r.status = '0;
    r.status[ST_DONE] = done;
    r.status[ST_VALID] = m_last_ok;
    r.status[ST_LINK] = m_link;
    r.status[ST_FAILED] = m_failed;
    r.status[ST_SWCHG] = m_swchg;
    expected_q.push_back(r);
  endtask

  task automatic send_item(bit m, logic [7:0] d);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= m;
    in_if.data_byte <= d;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_step(m, d);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_item(MODE_TICK, 8'($urandom_range(255)));
  endtask

  // Packs five channels and two switches into a frame; other bytes random, bytes 12 and 13 sometimes zero.
  task automatic send_frame(logic [10:0] c0, logic [10:0] c1, logic [10:0] c2,
                            logic [10:0] c3, logic [10:0] c4, logic [1:0] rsw,
                            logic [1:0] lsw);
    logic [7:0] b[rcd_pkg::FRAME_BYTES];
    for (int i = 0; i < rcd_pkg::FRAME_BYTES; i++) b[i] = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) b[12] = 8'h00;
    if ($urandom_range(3) == 0) b[13] = 8'h00;
    b[0] = c0[7:0];
    b[1] = {c1[4:0], c0[10:8]};
    b[2] = {c2[1:0], c1[10:5]};
    b[3] = c2[9:2];
    b[4] = {c3[6:0], c2[10]};
    b[5] = {lsw, rsw, c3[10:7]};
    b[16] = c4[7:0];
    b[17][2:0] = c4[10:8];
    for (int i = 0; i < rcd_pkg::FRAME_BYTES; i++) send_item(MODE_BYTE, b[i]);
  endtask

  task automatic send_raw_frame(logic [7:0] val);
    for (int i = 0; i < rcd_pkg::FRAME_BYTES; i++) send_item(MODE_BYTE, val);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [rcd_pkg::CFG_IDX_W-1:0] idx,
                           logic [rcd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rcd_pkg::REG_LOW:  m_low = val[10:0];
      rcd_pkg::REG_HIGH: m_high = val[10:0];
      rcd_pkg::REG_GAP:  m_gap = val[15:0];
      rcd_pkg::REG_DISC: m_disc = val;
      rcd_pkg::REG_FAIL: m_fail = val;
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_ticks(2);
    send_frame(11'd364, 11'd1684, 11'd364, 11'd1684, 11'd1024, 2'd3, 2'd1);
    send_raw_frame(8'hFF);
    send_raw_frame(8'h00);
    wait_drain();
  endtask

  task automatic test_config_extremes();
    cfg_write(rcd_pkg::REG_LOW, 24'd0);
    cfg_write(rcd_pkg::REG_HIGH, 24'h7FF);
    cfg_write(rcd_pkg::REG_GAP, 24'd3);
    cfg_write(rcd_pkg::REG_DISC, 24'd2);
    cfg_write(rcd_pkg::REG_FAIL, 24'd1);
    cfg_write(REG_BEYOND, 24'hFFFFFF);
    cfg_write(REG_TOP, 24'h000000);
    send_frame(11'd0, 11'h7FF, 11'd0, 11'h7FF, 11'h7FF, 2'd0, 2'd2);
    // A partial frame cut by a silence of exactly the gap.
    for (int i = 0; i < 5; i++) send_item(MODE_BYTE, 8'($urandom_range(255)));
    send_ticks(3);
    send_frame(11'd1, 11'd2, 11'd2046, 11'd1000, 11'd0, 2'd1, 2'd2);
    // Link drops.
    send_ticks(4);
    wait_drain();
    cfg_write(rcd_pkg::REG_LOW, 24'd1000);
    cfg_write(rcd_pkg::REG_HIGH, 24'd1000);
    send_frame(11'd1000, 11'd1000, 11'd1000, 11'd1000, 11'd1000, 2'd2, 2'd0);
    send_frame(11'd1000, 11'd1001, 11'd1000, 11'd1000, 11'd1000, 2'd1, 2'd3);
    wait_drain();
    cfg_write(rcd_pkg::REG_LOW, 24'd1200);
    cfg_write(rcd_pkg::REG_HIGH, 24'd800);
    cfg_write(rcd_pkg::REG_GAP, 24'd0);
    send_frame(11'd1000, 11'd1000, 11'd1000, 11'd1000, 11'd1000, 2'd0, 2'd0);
    wait_drain();
  endtask

  // A silence well past the gap restarts a partial frame.
  task automatic test_long_silence();
    cfg_write(rcd_pkg::REG_LOW, 24'd364);
    cfg_write(rcd_pkg::REG_HIGH, 24'd1684);
    cfg_write(rcd_pkg::REG_GAP, 24'd8);
    cfg_write(rcd_pkg::REG_DISC, 24'hFFFFFF);
    cfg_write(rcd_pkg::REG_FAIL, 24'hFFFFFF);
    for (int i = 0; i < 7; i++) send_item(MODE_BYTE, 8'($urandom_range(255)));
    send_ticks(40);
    send_frame(11'd500, 11'd600, 11'd700, 11'd800, 11'd900, 2'd2, 2'd1);
    wait_drain();
  endtask

  task automatic send_random_sequence();
    int kind;
    logic [10:0] c[5];
    kind = $urandom_range(99);
    for (int i = 0; i < 5; i++) begin
      if (m_low <= m_high && $urandom_range(99) < 85)
        c[i] = 11'($urandom_range(m_high, m_low));
      else
        c[i] = 11'($urandom_range(2047));
    end
    if (kind < 75) begin
      send_ticks(m_gap + $urandom_range(0, 2));
      send_frame(c[0], c[1], c[2], c[3], c[4], 2'($urandom_range(3)),
                 2'($urandom_range(3)));
      send_ticks($urandom_range(0, 12));
    end else if (kind < 90) begin
      for (int i = 0; i < $urandom_range(1, 17); i++)
        send_item(MODE_BYTE, 8'($urandom_range(255)));
      send_ticks($urandom_range(0, m_gap + 1));
    end else begin
      for (int i = 0; i < 10; i++)
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct);
    int start;
    cfg_write(rcd_pkg::REG_LOW, 24'($urandom_range(0, 600)));
    cfg_write(rcd_pkg::REG_HIGH, 24'($urandom_range(1400, 2047)));
    cfg_write(rcd_pkg::REG_GAP, 24'($urandom_range(1, 6)));
    cfg_write(rcd_pkg::REG_DISC, 24'($urandom_range(5, 40)));
    cfg_write(rcd_pkg::REG_FAIL, 24'($urandom_range(5, 60)));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < 110) send_random_sequence();
    wait_drain();
  endtask

  task automatic test_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req++;
    for (int i = 0; i < 3; i++) send_random_sequence();
    // Sender stops until everything has come out, then resumes.
    wait_drain();
    for (int i = 0; i < 2; i++) send_random_sequence();
    wait_drain();
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [23:0] e, logic [23:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, actual %0h", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    decoder_out_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("right_stick_x", e.stick[0], $unsigned(out_if.right_stick_x));
        check_field("right_stick_y", e.stick[1], $unsigned(out_if.right_stick_y));
        check_field("left_stick_x", e.stick[2], $unsigned(out_if.left_stick_x));
        check_field("left_stick_y", e.stick[3], $unsigned(out_if.left_stick_y));
        check_field("wheel", e.stick[4], $unsigned(out_if.wheel));
        check_field("right_switch", e.rsw, out_if.right_switch);
        check_field("left_switch", e.lsw, out_if.left_switch);
        check_field("mouse_x", e.mouse[0], $unsigned(out_if.mouse_x));
        check_field("mouse_y", e.mouse[1], $unsigned(out_if.mouse_y));
        check_field("mouse_z", e.mouse[2], $unsigned(out_if.mouse_z));
        check_field("buttons_and_keys", e.btn_keys, out_if.buttons_and_keys);
        check_field("status", e.status, out_if.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = MODE_TICK;
    in_if.data_byte = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_long_silence();
    test_random_phase(0, 0);
    test_random_phase(78, 0);
    test_random_phase(0, 78);
    test_random_phase(27, 27);
    test_pressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
